[rtl/olnp_pkg.sv]
// ----------------------------------------------------------------------------
// olnp_pkg
// Shared types and constants of the ordered list node pool engine.
// ----------------------------------------------------------------------------
package olnp_pkg;

  localparam int unsigned POOL_NODES  = 64;
  localparam int unsigned HW          = 6;   // node handle width
  localparam int unsigned LW          = 7;   // link width, top bit marks none
  localparam int unsigned FUNC_W      = 4;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned TDATA_IN_W  = 80;
  localparam int unsigned TDATA_OUT_W = 80;

  typedef logic [HW-1:0] handle_t;
  typedef logic [LW-1:0] link_t;

  localparam link_t LINK_NONE = link_t'(POOL_NODES);

  typedef enum logic [FUNC_W-1:0] {
    F_APPEND     = 4'd0,
    F_INS_AT     = 4'd1,
    F_INS_BEFORE = 4'd2,
    F_INS_AFTER  = 4'd3,
    F_REM_NODE   = 4'd4,
    F_REM_VALUE  = 4'd5,
    F_REM_AT     = 4'd6,
    F_REM_FIRST  = 4'd7,
    F_REM_LAST   = 4'd8,
    F_FIND_FWD   = 4'd9,
    F_FIND_REV   = 4'd10,
    F_NODE_AT    = 4'd11,
    F_POS_OF     = 4'd12,
    F_MOVE       = 4'd13,
    F_REPLACE    = 4'd14,
    F_READ       = 4'd15
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_FULL        = 3'd2,
    ST_NOT_IN_LIST = 3'd3,
    ST_EMPTY       = 3'd4
  } status_e;

  typedef struct packed {
    link_t nxt;
    link_t prv;
  } links_t;

  typedef struct packed {
    handle_t rd_addr;
    handle_t wr_addr;
    logic    we_next;
    logic    we_prev;
    logic    we_data;
    links_t  wr_links;
  } mem_req_t;

  typedef struct packed {
    func_e       func;
    handle_t     position;
    logic [31:0] value;
    logic [31:0] new_value;
    handle_t     node;
    logic        absent;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    handle_t     found_node;
    handle_t     found_position;
    logic [31:0] node_value;
    handle_t     prev_node;
    logic        prev_valid;
    handle_t     next_node;
    logic        next_valid;
    logic [6:0]  length;
    handle_t     head_node;
    handle_t     tail_node;
  } result_t;

endpackage

[rtl/olnp_store.sv]
// ----------------------------------------------------------------------------
// olnp_store
// Node pool memories: link memory with per-field write enables and data
// memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module olnp_store #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  olnp_pkg::mem_req_t  req_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  output olnp_pkg::links_t    rd_links_o,
  output logic [DATA_WIDTH-1:0] rd_data_o
);
  import olnp_pkg::*;

  links_t                link_mem [POOL_NODES];
  logic [DATA_WIDTH-1:0] data_mem [POOL_NODES];

  always_ff @(posedge clk_i) begin
    if (req_i.we_next) begin
      link_mem[req_i.wr_addr].nxt <= req_i.wr_links.nxt;
    end
    if (req_i.we_prev) begin
      link_mem[req_i.wr_addr].prv <= req_i.wr_links.prv;
    end
    if (req_i.we_data) begin
      data_mem[req_i.wr_addr] <= wr_data_i;
    end
    rd_links_o <= link_mem[req_i.rd_addr];
    rd_data_o  <= data_mem[req_i.rd_addr];
  end

endmodule

[rtl/olnp_ctrl.sv]
// ----------------------------------------------------------------------------
// olnp_ctrl
// Command sequencer: list walks one node per cycle, free slot scan, link
// read-modify-write, head/tail/count and the in-use bits.
// ----------------------------------------------------------------------------
module olnp_ctrl #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  olnp_pkg::cmd_t        cmd_i,
  output logic                  ready_o,
  output logic                  res_valid_o,
  input  logic                  res_take_i,
  output olnp_pkg::result_t     res_o,
  output olnp_pkg::mem_req_t    mem_req_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o,
  input  olnp_pkg::links_t      mem_links_i,
  input  logic [DATA_WIDTH-1:0] mem_rdata_i
);
  import olnp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISPATCH = 12'b0000_0000_0010,
    S_WALK_RD  = 12'b0000_0000_0100,
    S_WALK     = 12'b0000_0000_1000,
    S_SCAN     = 12'b0000_0001_0000,
    S_LK_RD    = 12'b0000_0010_0000,
    S_LK_CAP   = 12'b0000_0100_0000,
    S_LK_WN    = 12'b0000_1000_0000,
    S_LK_WP    = 12'b0001_0000_0000,
    S_LK_WQ    = 12'b0010_0000_0000,
    S_REPL     = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [1:0] {K_AT, K_POS, K_FIND} kind_e;
  typedef enum logic [2:0] {
    P_BASE, P_LOCATE, P_REMOVE, P_MOVE_OLD, P_MOVE_TGT, P_FINAL
  } purpose_e;
  typedef enum logic [1:0] {INS_APPEND, INS_BEFORE, INS_AFTER} ins_e;
  typedef enum logic [1:0] {LK_INSERT, LK_UNLINK_REM, LK_UNLINK_MOVE} lkop_e;

  typedef struct packed {
    link_t    cur;
    logic     dir;      // 1: walk toward the head
    kind_e    kind;
    handle_t  steps;
    purpose_e purpose;
  } walk_t;

  function automatic walk_t mk_walk(link_t c, logic d, kind_e k, handle_t s,
                                    purpose_e p);
    walk_t w;
    w.cur     = c;
    w.dir     = d;
    w.kind    = k;
    w.steps   = s;
    w.purpose = p;
    return w;
  endfunction

  // control state
  state_e                 state_q, state_d;
  link_t                  head_q, head_d, tail_q, tail_d;
  logic [6:0]             count_q, count_d;
  logic [POOL_NODES-1:0]  used_q, used_d;

  // per-command payload
  cmd_t        cmd_q, cmd_d;
  status_e     status_q, status_d;
  handle_t     n_q, n_d, base_q, base_d, scan_q, scan_d, idx_q, idx_d, old_q, old_d;
  ins_e        ins_q, ins_d;
  lkop_e       lkop_q, lkop_d;
  logic        removed_q, removed_d;
  walk_t       walk_q, walk_d;
  link_t       p_q, p_d, q_q, q_d, r_prev_q, r_prev_d, r_next_q, r_next_d;
  handle_t     r_pos_q, r_pos_d;
  logic [31:0] r_data_q, r_data_d;

  logic [6:0]            half, pos7;
  logic                  at_from_tail, used_node, val_fits, match, hit, walk_hit, walk_miss;
  link_t                 at_start, walk_link, lk_val;
  handle_t               at_steps, hit_node;
  logic [DATA_WIDTH-1:0] val_w;
  logic                  ok;

  assign half         = count_q >> 1;
  assign pos7         = {1'b0, cmd_q.position};
  assign at_from_tail = !(pos7 < half);
  assign at_start     = at_from_tail ? tail_q : head_q;
  assign at_steps     = at_from_tail ? HW'(count_q - 7'd1 - pos7) : cmd_q.position;
  assign used_node    = used_q[cmd_q.node];
  assign val_w        = DATA_WIDTH'(cmd_q.value);
  // a word wider than the stored data can never match
  assign val_fits     = (32'(val_w) == cmd_q.value);
  assign match        = (cmd_q.value != 32'd0) && val_fits && (mem_rdata_i == val_w);
  assign walk_link    = walk_q.dir ? mem_links_i.prv : mem_links_i.nxt;
  assign hit_node     = walk_q.cur[HW-1:0];

  always_comb begin
    if (walk_q.kind == K_AT) begin
      hit = (idx_q == walk_q.steps);
    end else if (walk_q.kind == K_POS) begin
      hit = (walk_q.cur == {1'b0, n_q});
    end else begin
      hit = match;
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    used_d    = used_q;
    cmd_d     = cmd_q;
    status_d  = status_q;
    n_d       = n_q;
    base_d    = base_q;
    scan_d    = scan_q;
    idx_d     = idx_q;
    old_d     = old_q;
    ins_d     = ins_q;
    lkop_d    = lkop_q;
    removed_d = removed_q;
    walk_d    = walk_q;
    p_d       = p_q;
    q_d       = q_q;
    r_prev_d  = r_prev_q;
    r_next_d  = r_next_q;
    r_pos_d   = r_pos_q;
    r_data_d  = r_data_q;
    walk_hit  = 1'b0;
    walk_miss = 1'b0;
    lk_val    = LINK_NONE;

    mem_req_o.rd_addr  = walk_q.cur[HW-1:0];
    mem_req_o.wr_addr  = n_q;
    mem_req_o.we_next  = 1'b0;
    mem_req_o.we_prev  = 1'b0;
    mem_req_o.we_data  = 1'b0;
    mem_req_o.wr_links = '{nxt: q_q, prv: p_q};
    mem_wdata_o        = val_w;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d     = cmd_i;
          status_d  = ST_OK;
          removed_d = 1'b0;
          state_d   = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        idx_d  = '0;
        scan_d = '0;
        unique case (cmd_q.func)
          F_APPEND: begin
            ins_d   = INS_APPEND;
            state_d = S_SCAN;
          end
          F_INS_AT: begin
            if (pos7 < count_q) begin
              walk_d  = mk_walk(at_start, at_from_tail, K_AT, at_steps, P_BASE);
              state_d = S_WALK_RD;
            end else begin
              ins_d   = INS_APPEND;
              state_d = S_SCAN;
            end
          end
          F_INS_BEFORE, F_INS_AFTER: begin
            if (!cmd_q.absent && !used_node) begin
              status_d = ST_NOT_IN_LIST;
              state_d  = S_DONE;
            end else begin
              base_d  = cmd_q.node;
              ins_d   = cmd_q.absent ? INS_APPEND :
                        (cmd_q.func == F_INS_BEFORE) ? INS_BEFORE : INS_AFTER;
              state_d = S_SCAN;
            end
          end
          F_REM_NODE, F_POS_OF, F_READ, F_MOVE: begin
            if (!used_node) begin
              status_d = ST_NOT_IN_LIST;
              state_d  = S_DONE;
            end else begin
              n_d       = cmd_q.node;
              removed_d = (cmd_q.func == F_REM_NODE);
              walk_d    = mk_walk(head_q, 1'b0, K_POS, '0,
                                  (cmd_q.func == F_REM_NODE) ? P_REMOVE :
                                  (cmd_q.func == F_MOVE) ? P_MOVE_OLD : P_FINAL);
              state_d   = S_WALK_RD;
            end
          end
          F_REM_VALUE, F_FIND_FWD, F_REPLACE: begin
            walk_d  = mk_walk(head_q, 1'b0, K_FIND, '0, P_LOCATE);
            state_d = S_WALK_RD;
          end
          F_FIND_REV: begin
            walk_d  = mk_walk(tail_q, 1'b1, K_FIND, '0, P_LOCATE);
            state_d = S_WALK_RD;
          end
          F_REM_AT, F_NODE_AT: begin
            if (count_q == 7'd0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else if (!(pos7 < count_q)) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end else begin
              walk_d  = mk_walk(at_start, at_from_tail, K_AT, at_steps, P_LOCATE);
              state_d = S_WALK_RD;
            end
          end
          F_REM_FIRST, F_REM_LAST: begin
            if (count_q == 7'd0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              n_d       = (cmd_q.func == F_REM_FIRST) ? head_q[HW-1:0] : tail_q[HW-1:0];
              removed_d = 1'b1;
              walk_d    = mk_walk(head_q, 1'b0, K_POS, '0, P_REMOVE);
              state_d   = S_WALK_RD;
            end
          end
        endcase
      end

      S_WALK_RD: begin
        if (walk_q.cur[LW-1]) begin
          walk_miss = 1'b1;
        end else begin
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        if (hit) begin
          walk_hit = 1'b1;
        end else if (walk_link[LW-1] || (idx_q == {HW{1'b1}})) begin
          walk_miss = 1'b1;
        end else begin
          // chase the link straight out of the read port
          walk_d.cur        = walk_link;
          idx_d             = idx_q + HW'(1);
          mem_req_o.rd_addr = walk_link[HW-1:0];
        end
      end

      S_SCAN: begin
        if (!used_q[scan_q]) begin
          n_d            = scan_q;
          used_d[scan_q] = 1'b1;
          lkop_d         = LK_INSERT;
          if (ins_q == INS_APPEND) begin
            p_d     = tail_q;
            q_d     = LINK_NONE;
            state_d = S_LK_WN;
          end else begin
            state_d = S_LK_RD;
          end
        end else if (scan_q == HW'(POOL_NODES - 1)) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          scan_d = scan_q + HW'(1);
        end
      end

      S_LK_RD: begin
        mem_req_o.rd_addr = base_q;
        state_d           = S_LK_CAP;
      end

      S_LK_CAP: begin
        if (ins_q == INS_BEFORE) begin
          p_d = mem_links_i.prv;
          q_d = {1'b0, base_q};
        end else begin
          p_d = {1'b0, base_q};
          q_d = mem_links_i.nxt;
        end
        state_d = S_LK_WN;
      end

      S_LK_WN: begin
        mem_req_o.wr_addr = n_q;
        mem_req_o.we_next = 1'b1;
        mem_req_o.we_prev = 1'b1;
        mem_req_o.we_data = (cmd_q.func != F_MOVE);
        state_d           = S_LK_WP;
      end

      S_LK_WP: begin
        lk_val = (lkop_q == LK_INSERT) ? {1'b0, n_q} : q_q;
        if (!p_q[LW-1]) begin
          mem_req_o.wr_addr      = p_q[HW-1:0];
          mem_req_o.we_next      = 1'b1;
          mem_req_o.wr_links.nxt = lk_val;
        end else begin
          head_d = lk_val;
        end
        state_d = S_LK_WQ;
      end

      S_LK_WQ: begin
        lk_val = (lkop_q == LK_INSERT) ? {1'b0, n_q} : p_q;
        if (!q_q[LW-1]) begin
          mem_req_o.wr_addr      = q_q[HW-1:0];
          mem_req_o.we_prev      = 1'b1;
          mem_req_o.wr_links.prv = lk_val;
        end else begin
          tail_d = lk_val;
        end
        count_d = (lkop_q == LK_INSERT) ? count_q + 7'd1 : count_q - 7'd1;
        if (lkop_q == LK_INSERT) begin
          idx_d   = '0;
          walk_d  = mk_walk(head_q, 1'b0, K_POS, '0, P_FINAL);
          state_d = S_WALK_RD;
        end else if (lkop_q == LK_UNLINK_REM) begin
          used_d[n_q] = 1'b0;
          state_d     = S_DONE;
        end else begin
          lkop_d  = LK_INSERT;
          state_d = S_LK_RD;
        end
      end

      S_REPL: begin
        mem_req_o.wr_addr = n_q;
        mem_req_o.we_data = 1'b1;
        mem_wdata_o       = DATA_WIDTH'(cmd_q.new_value);
        idx_d             = '0;
        walk_d            = mk_walk(head_q, 1'b0, K_POS, '0, P_FINAL);
        state_d           = S_WALK_RD;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (walk_hit) begin
      idx_d = '0;
      unique case (walk_q.purpose)
        P_BASE: begin
          base_d  = hit_node;
          ins_d   = INS_BEFORE;
          scan_d  = '0;
          state_d = S_SCAN;
        end
        P_LOCATE: begin
          n_d = hit_node;
          if ((cmd_q.func == F_REM_VALUE) || (cmd_q.func == F_REM_AT)) begin
            removed_d = 1'b1;
            walk_d    = mk_walk(head_q, 1'b0, K_POS, '0, P_REMOVE);
            state_d   = S_WALK_RD;
          end else if (cmd_q.func == F_REPLACE) begin
            state_d = S_REPL;
          end else begin
            walk_d  = mk_walk(head_q, 1'b0, K_POS, '0, P_FINAL);
            state_d = S_WALK_RD;
          end
        end
        P_REMOVE: begin
          r_pos_d  = idx_q;
          r_data_d = 32'(mem_rdata_i);
          p_d      = mem_links_i.prv;
          q_d      = mem_links_i.nxt;
          lkop_d   = LK_UNLINK_REM;
          state_d  = S_LK_WP;
        end
        P_MOVE_OLD: begin
          old_d    = idx_q;
          p_d      = mem_links_i.prv;
          q_d      = mem_links_i.nxt;
          r_pos_d  = idx_q;
          r_data_d = 32'(mem_rdata_i);
          r_prev_d = mem_links_i.prv;
          r_next_d = mem_links_i.nxt;
          if ((cmd_q.position != idx_q) && (pos7 < count_q)) begin
            walk_d  = mk_walk(at_start, at_from_tail, K_AT, at_steps, P_MOVE_TGT);
            state_d = S_WALK_RD;
          end else begin
            state_d = S_DONE;
          end
        end
        P_MOVE_TGT: begin
          base_d  = hit_node;
          ins_d   = (cmd_q.position < old_q) ? INS_BEFORE : INS_AFTER;
          lkop_d  = LK_UNLINK_MOVE;
          state_d = S_LK_WP;
        end
        P_FINAL: begin
          r_pos_d  = idx_q;
          r_data_d = 32'(mem_rdata_i);
          r_prev_d = mem_links_i.prv;
          r_next_d = mem_links_i.nxt;
          state_d  = S_DONE;
        end
        default: begin
          state_d = S_DONE;
        end
      endcase
    end

    if (walk_miss) begin
      idx_d = '0;
      unique case (walk_q.purpose)
        P_BASE: begin
          ins_d   = INS_APPEND;
          scan_d  = '0;
          state_d = S_SCAN;
        end
        P_LOCATE: begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end
        P_MOVE_TGT: begin
          walk_d  = mk_walk(head_q, 1'b0, K_POS, '0, P_FINAL);
          state_d = S_WALK_RD;
        end
        default: begin
          r_pos_d  = '0;
          r_data_d = '0;
          r_prev_d = LINK_NONE;
          r_next_d = LINK_NONE;
          state_d  = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= LINK_NONE;
      tail_q  <= LINK_NONE;
      count_q <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    status_q  <= status_d;
    n_q       <= n_d;
    base_q    <= base_d;
    scan_q    <= scan_d;
    idx_q     <= idx_d;
    old_q     <= old_d;
    ins_q     <= ins_d;
    lkop_q    <= lkop_d;
    removed_q <= removed_d;
    walk_q    <= walk_d;
    p_q       <= p_d;
    q_q       <= q_d;
    r_prev_q  <= r_prev_d;
    r_next_q  <= r_next_d;
    r_pos_q   <= r_pos_d;
    r_data_q  <= r_data_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign ok          = (status_q == ST_OK);

  always_comb begin
    res_o.status         = status_q;
    res_o.found_node     = ok ? n_q : '0;
    res_o.found_position = ok ? r_pos_q : '0;
    res_o.node_value     = ok ? r_data_q : '0;
    res_o.prev_valid     = ok && !removed_q && !r_prev_q[LW-1];
    res_o.prev_node      = res_o.prev_valid ? r_prev_q[HW-1:0] : '0;
    res_o.next_valid     = ok && !removed_q && !r_next_q[LW-1];
    res_o.next_node      = res_o.next_valid ? r_next_q[HW-1:0] : '0;
    res_o.length         = count_q;
    res_o.head_node      = ((count_q != 7'd0) && !head_q[LW-1]) ? head_q[HW-1:0] : '0;
    res_o.tail_node      = ((count_q != 7'd0) && !tail_q[LW-1]) ? tail_q[HW-1:0] : '0;
  end

endmodule

[rtl/ordered_list_node_pool_engine_top.sv]
// ----------------------------------------------------------------------------
// ordered_list_node_pool_engine_top
// Doubly linked ordered list in a fixed pool of 64 nodes.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tuser: func; tdata: position, value, new_value, node, node_absent
//  m_axis    | out       | tuser: status; tdata: found node, position, data, links,
//            |           |        length, head, tail
//
// one request at a time; a request rejected at dispatch goes straight from
// dispatch to done, others walk the list one node per cycle and, for inserts,
// scan the pool one slot per cycle for the lowest free node. the single read
// port of the link memory sets the walk rate.
// reset clears the in-use bits, head, tail and count at once; no clearing pass.
// a finished result sits in the output register; the next request is taken
// meanwhile and its result waits until that register is free.
// ----------------------------------------------------------------------------
module ordered_list_node_pool_engine_top #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // position[5:0], value[37:6], new_value[69:38], node[75:70], node_absent[76]
  input  logic [olnp_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
  // func[3:0]
  input  logic [olnp_pkg::FUNC_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // found_node[5:0], found_position[11:6], node_value[43:12], prev_node[49:44],
  // prev_valid[50], next_node[56:51], next_valid[57], length[64:58],
  // head_node[70:65], tail_node[76:71]
  output logic [olnp_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
  // status[2:0]
  output logic [olnp_pkg::STATUS_W-1:0]        m_axis_tuser
);
  import olnp_pkg::*;

  cmd_t                  cmd;
  result_t               res;
  mem_req_t              mem_req;
  links_t                mem_links;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                  ready, start, res_valid, res_take;

  logic                   m_valid_q, m_valid_d;
  logic [TDATA_OUT_W-1:0] m_data_q, m_data_d;
  logic [STATUS_W-1:0]    m_user_q, m_user_d;

  assign cmd.func      = func_e'(s_axis_tuser);
  assign cmd.position  = s_axis_tdata[5:0];
  assign cmd.value     = s_axis_tdata[37:6];
  assign cmd.new_value = s_axis_tdata[69:38];
  assign cmd.node      = s_axis_tdata[75:70];
  assign cmd.absent    = s_axis_tdata[76];

  assign s_axis_tready = ready;
  assign start         = s_axis_tvalid && ready;
  assign res_take      = res_valid && (!m_valid_q || m_axis_tready);

  olnp_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .ready_o     (ready),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_wdata_o (mem_wdata),
    .mem_links_i (mem_links),
    .mem_rdata_i (mem_rdata)
  );

  olnp_store #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_store (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .wr_data_i  (mem_wdata),
    .rd_links_o (mem_links),
    .rd_data_o  (mem_rdata)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (res_take) begin
      m_valid_d = 1'b1;
      m_user_d  = res.status;
      m_data_d  = {3'b000, res.tail_node, res.head_node, res.length,
                   res.next_valid, res.next_node, res.prev_valid, res.prev_node,
                   res.node_value, res.found_position, res.found_node};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[rtl/olnp_checker.sv]
// ----------------------------------------------------------------------------
// olnp_checker
// Port-level checks of the ordered list node pool engine, bound to the top.
// ----------------------------------------------------------------------------
module olnp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [olnp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  input logic [olnp_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import olnp_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // the engine runs one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request taken while busy");

  // a failed request reports no node, data or neighbors
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_W'(ST_OK)) |-> (m_axis_tdata[57:0] == '0))
    else $error("failed request carries node fields");

  // empty list shows zero head and tail, length never past the pool
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[64:58] <= 7'(POOL_NODES))
    && ((m_axis_tdata[64:58] != 7'd0) || (m_axis_tdata[76:65] == '0)))
    else $error("bad length, head or tail");

endmodule

bind ordered_list_node_pool_engine_top olnp_checker u_olnp_checker (.*);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the ordered list node pool engine: a directed table of list commands
// with typed-in results where obvious, then random command streams checked
// against a behavioral list model, with random idling and backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import olnp_pkg::*;

  localparam int NPOOL = 64;
  localparam int NONE = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 330;

  typedef struct {
    func_e       func;
    logic [5:0]  position;
    logic [31:0] value;
    logic [31:0] new_value;
    logic [5:0]  node;
    logic        absent;
  } list_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found_node;
    logic [5:0]  found_position;
    logic [31:0] node_value;
    logic [5:0]  prev_node;
    logic        prev_valid;
    logic [5:0]  next_node;
    logic        next_valid;
    logic [6:0]  length;
    logic [5:0]  head_node;
    logic [5:0]  tail_node;
  } list_result_t;

  typedef struct {
    list_cmd_t    cmd;
    logic         has_result;
    list_result_t res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  // list model state
  int     nxt_l[NPOOL];
  int     prv_l[NPOOL];
  logic [31:0] data_l[NPOOL];
  bit     used_l[NPOOL];
  int     head_l, tail_l, count_l;

  list_result_t pending_results[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  bit  no_idle = 0;
  bit  long_hold = 0;

  ordered_list_node_pool_engine_top i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int list_node_at(int p);
    int n, i;
    if (p >= count_l) return NONE;
    if (p < count_l / 2) begin
      n = head_l;
      for (i = 0; i < p && n < NONE; i++) n = nxt_l[n];
    end else begin
      n = tail_l;
      for (i = count_l - 1; i > p && n < NONE; i--) n = prv_l[n];
    end
    return n;
  endfunction

  function automatic int list_pos_of(int t);
    int n, i;
    n = head_l;
    for (i = 0; i < NPOOL && n < NONE; i++) begin
      if (n == t) return i;
      n = nxt_l[n];
    end
    return 0;
  endfunction

  function automatic int list_find(logic [31:0] v, bit rev);
    int n, i;
    n = rev ? tail_l : head_l;
    if (v == 0) return NONE;
    for (i = 0; i < NPOOL && n < NONE; i++) begin
      if (data_l[n] == v) return n;
      n = rev ? prv_l[n] : nxt_l[n];
    end
    return NONE;
  endfunction

  function automatic void list_unlink(int n);
    int p, q;
    p = prv_l[n];
    q = nxt_l[n];
    if (p < NONE) nxt_l[p] = q; else head_l = q;
    if (q < NONE) prv_l[q] = p; else tail_l = p;
    if (count_l > 0) count_l--;
  endfunction

  function automatic void list_link_before(int n, int b);
    int p;
    if (b >= NONE) begin
      prv_l[n] = tail_l;
      nxt_l[n] = NONE;
      if (tail_l < NONE) nxt_l[tail_l] = n; else head_l = n;
      tail_l = n;
    end else begin
      p = prv_l[b];
      prv_l[n] = p;
      nxt_l[n] = b;
      prv_l[b] = n;
      if (p < NONE) nxt_l[p] = n; else head_l = n;
    end
    count_l++;
  endfunction

  function automatic void list_link_after(int n, int b);
    int q;
    q = nxt_l[b];
    prv_l[n] = b;
    nxt_l[n] = q;
    nxt_l[b] = n;
    if (q < NONE) prv_l[q] = n; else tail_l = n;
    count_l++;
  endfunction

  function automatic int list_alloc(logic [31:0] v);
    for (int i = 0; i < NPOOL; i++) begin
      if (!used_l[i]) begin
        used_l[i] = 1;
        data_l[i] = v;
        prv_l[i] = NONE;
        nxt_l[i] = NONE;
        return i;
      end
    end
    return NONE;
  endfunction

  function automatic list_result_t list_execute(list_cmd_t c);
    list_result_t r;
    status_e st;
    int n, b, old, tgt, rpos;
    bit removed;
    st = ST_OK;
    n = NONE;
    removed = 0;
    rpos = 0;
    case (c.func)
      F_APPEND, F_INS_AT: begin
        b = (c.func == F_INS_AT && c.position < count_l) ? list_node_at(c.position) : NONE;
        n = list_alloc(c.value);
        if (n == NONE) st = ST_FULL; else list_link_before(n, b);
      end
      F_INS_BEFORE, F_INS_AFTER: begin
        if (!c.absent && !used_l[c.node]) st = ST_NOT_IN_LIST;
        else begin
          n = list_alloc(c.value);
          if (n == NONE) st = ST_FULL;
          else if (c.absent) list_link_before(n, NONE);
          else if (c.func == F_INS_BEFORE) list_link_before(n, c.node);
          else list_link_after(n, c.node);
        end
      end
      F_REM_NODE: begin
        if (!used_l[c.node]) st = ST_NOT_IN_LIST;
        else begin
          n = c.node;
          removed = 1;
        end
      end
      F_REM_VALUE: begin
        n = list_find(c.value, 0);
        if (n == NONE) st = ST_NOT_FOUND; else removed = 1;
      end
      F_REM_AT, F_REM_FIRST, F_REM_LAST, F_NODE_AT: begin
        if (count_l == 0) st = ST_EMPTY;
        else begin
          n = (c.func == F_REM_FIRST) ? head_l : (c.func == F_REM_LAST) ? tail_l :
              list_node_at(c.position);
          if (n == NONE) st = ST_NOT_FOUND;
          else if (c.func != F_NODE_AT) removed = 1;
        end
      end
      F_FIND_FWD, F_FIND_REV, F_REPLACE: begin
        n = list_find(c.value, c.func == F_FIND_REV);
        if (n == NONE) st = ST_NOT_FOUND;
        else if (c.func == F_REPLACE) data_l[n] = c.new_value;
      end
      F_MOVE: begin
        if (!used_l[c.node]) st = ST_NOT_IN_LIST;
        else begin
          n = c.node;
          old = list_pos_of(n);
          if (c.position != old && c.position < count_l) begin
            tgt = list_node_at(c.position);
            if (tgt < NONE && tgt != n) begin
              list_unlink(n);
              if (c.position < old) list_link_before(n, tgt);
              else list_link_after(n, tgt);
            end
          end
        end
      end
      default: begin
        if (!used_l[c.node]) st = ST_NOT_IN_LIST; else n = c.node;
      end
    endcase
    if (st == ST_OK && removed) begin
      rpos = list_pos_of(n);
      list_unlink(n);
      used_l[n] = 0;
    end
    r = '{default: '0};
    r.status = st;
    if (st == ST_OK && n < NONE) begin
      r.found_node = n[5:0];
      r.found_position = removed ? rpos[5:0] : 6'(list_pos_of(n));
      r.node_value = data_l[n];
      if (!removed) begin
        if (prv_l[n] < NONE) begin
          r.prev_node = 6'(prv_l[n]);
          r.prev_valid = 1;
        end
        if (nxt_l[n] < NONE) begin
          r.next_node = 6'(nxt_l[n]);
          r.next_valid = 1;
        end
      end
    end
    r.length = 7'(count_l);
    r.head_node = (count_l != 0) ? head_l[5:0] : '0;
    r.tail_node = (count_l != 0) ? tail_l[5:0] : '0;
    return r;
  endfunction

  // one request; blocks until accepted
  task automatic send_request(list_cmd_t c, bit typed, list_result_t typed_res);
    list_result_t r;
    r = list_execute(c);
    if (typed && r != typed_res) begin
      $display("%0t table row disagrees with model: exp %p got %p", $time, typed_res, r);
      errors++;
    end
    pending_results.push_back(typed ? typed_res : r);
    s_axis_tdata <= {3'b0, c.absent, c.node, c.new_value, c.value, c.position};
    s_axis_tuser <= c.func;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic sender_gap();
    int g;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      g = $urandom_range(1, 19);
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic list_cmd_t rand_cmd();
    list_cmd_t c;
    int k;
    k = $urandom_range(0, 99);
    // keep the list mostly half full, inserts dominate when short
    if (k < ((count_l < 20) ? 45 : (count_l > 56) ? 15 : 30))
      c.func = func_e'($urandom_range(0, 3));
    else
      c.func = func_e'($urandom_range(4, 15));
    c.position = ($urandom_range(0, 4) == 0) ? 6'($urandom) :
                 6'($urandom_range(0, (count_l > 0) ? count_l : 0));
    c.value = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
    if ($urandom_range(0, 2) == 0 && count_l > 0 && c.func inside {F_REM_VALUE,
        F_FIND_FWD, F_FIND_REV, F_REPLACE}) c.value = data_l[list_node_at(
        $urandom_range(0, count_l - 1))];
    c.new_value = $urandom;
    c.node = ($urandom_range(0, 4) == 0 || count_l == 0) ? 6'($urandom) :
             6'(list_node_at($urandom_range(0, count_l - 1)));
    c.absent = ($urandom_range(0, 5) == 0);
    return c;
  endfunction

  function automatic list_cmd_t mk(func_e f, int p, logic [31:0] v, logic [31:0] nv,
                                   int nd, bit a);
    list_cmd_t c;
    c.func = f;
    c.position = 6'(p);
    c.value = v;
    c.new_value = nv;
    c.node = 6'(nd);
    c.absent = a;
    return c;
  endfunction

  function automatic list_result_t err_res(status_e st, int len, int h, int t);
    list_result_t r;
    r = '{default: '0};
    r.status = st;
    r.length = 7'(len);
    r.head_node = 6'(h);
    r.tail_node = 6'(t);
    return r;
  endfunction

  // stimulus
  initial begin
    stim_row_t table_rows[$];
    list_cmd_t c;
    head_l = NONE;
    tail_l = NONE;
    count_l = 0;
    for (int i = 0; i < NPOOL; i++) used_l[i] = 0;

    table_rows.push_back('{mk(F_REM_FIRST, 0, 0, 0, 0, 0), 1, err_res(ST_EMPTY, 0, 0, 0)});
    table_rows.push_back('{mk(F_REM_LAST, 0, 0, 0, 0, 0), 1, err_res(ST_EMPTY, 0, 0, 0)});
    table_rows.push_back('{mk(F_REM_AT, 63, 0, 0, 0, 0), 1, err_res(ST_EMPTY, 0, 0, 0)});
    table_rows.push_back('{mk(F_NODE_AT, 0, 0, 0, 0, 0), 1, err_res(ST_EMPTY, 0, 0, 0)});
    table_rows.push_back('{mk(F_FIND_FWD, 0, 32'hffff_ffff, 0, 0, 0), 1,
                           err_res(ST_NOT_FOUND, 0, 0, 0)});
    table_rows.push_back('{mk(F_READ, 0, 0, 0, 63, 0), 1, err_res(ST_NOT_IN_LIST, 0, 0, 0)});
    table_rows.push_back('{mk(F_INS_BEFORE, 0, 5, 0, 7, 0), 1,
                           err_res(ST_NOT_IN_LIST, 0, 0, 0)});
    table_rows.push_back('{mk(F_APPEND, 0, 32'hffff_ffff, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_APPEND, 0, 0, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_INS_AT, 0, 32'h1234_5678, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_INS_AT, 63, 32'h8000_0001, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_INS_BEFORE, 0, 11, 0, 1, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_INS_AFTER, 0, 12, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_INS_AFTER, 0, 13, 0, 0, 1), 0, '{default: '0}});
    table_rows.push_back('{mk(F_FIND_FWD, 0, 0, 0, 0, 0), 1, err_res(ST_NOT_FOUND, 7, 2, 6)});
    table_rows.push_back('{mk(F_FIND_REV, 0, 12, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_NODE_AT, 63, 0, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_NODE_AT, 5, 0, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_POS_OF, 0, 0, 0, 3, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_MOVE, 0, 0, 0, 3, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_MOVE, 63, 0, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_REPLACE, 0, 13, 32'hdead_beef, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_REM_VALUE, 0, 32'hdead_beef, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_REM_NODE, 0, 0, 0, 0, 0), 0, '{default: '0}});
    table_rows.push_back('{mk(F_REM_AT, 2, 0, 0, 0, 0), 0, '{default: '0}});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      send_request(table_rows[i].cmd, table_rows[i].has_result, table_rows[i].res);
      sender_gap();
    end

    // fill the pool to hit the full case, receiver held off meanwhile
    long_hold = 1;
    while (count_l < NPOOL) begin
      c = mk(F_APPEND, 0, $urandom, 0, 0, 0);
      send_request(c, 0, '{default: '0});
    end
    send_request(mk(F_INS_AFTER, 0, 1, 0, 0, 1), 1, err_res(ST_FULL, 64, head_l, tail_l));
    s_axis_tvalid <= 1'b0;
    long_hold = 0;
    // pause until the queue drains
    while (pending_results.size() != 0) @(posedge clk_i);
    // shrink to a mid-size list
    while (count_l > 24) begin
      send_request(mk(F_REM_LAST, 0, 0, 0, 0, 0), 0, '{default: '0});
      sender_gap();
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 60) no_idle = 1;
      c = rand_cmd();
      send_request(c, 0, '{default: '0});
      sender_gap();
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  // receiver backpressure
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        n = 0;
        while (long_hold && n < 3000) begin
          @(posedge clk_i);
          n++;
        end
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk_i) begin
    list_result_t exp_r, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.found_node = m_axis_tdata[5:0];
      got.found_position = m_axis_tdata[11:6];
      got.node_value = m_axis_tdata[43:12];
      got.prev_node = m_axis_tdata[49:44];
      got.prev_valid = m_axis_tdata[50];
      got.next_node = m_axis_tdata[56:51];
      got.next_valid = m_axis_tdata[57];
      got.length = m_axis_tdata[64:58];
      got.head_node = m_axis_tdata[70:65];
      got.tail_node = m_axis_tdata[76:71];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
